### rtl/gap_buffer_text_store_defines.svh
`ifndef GAP_BUFFER_TEXT_STORE_DEFINES_SVH
`define GAP_BUFFER_TEXT_STORE_DEFINES_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define GBTS_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("gap buffer check failed");

// Checks that a condition holds in the cycle after its trigger.
`define GBTS_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("gap buffer check failed");

`endif

### rtl/gbts_pkg.sv
package gbts_pkg;

  localparam logic [2:0] CMD_GOTO   = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_READ   = 3'd3;
  localparam logic [2:0] CMD_NEEDLE = 3'd4;
  localparam logic [2:0] CMD_SEARCH = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_INVALID   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_MOVE, S_MOVE_WR, S_READ_WAIT, S_SRCH_RD, S_SRCH_CMP, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    DP_NONE, DP_LOAD, DP_MOVE_RD, DP_MOVE_WR, DP_APPLY, DP_READ_ISSUE, DP_READ_DONE,
    DP_SRCH_INIT, DP_SRCH_RD, DP_SRCH_NEXTJ, DP_SRCH_NEXTI, DP_SRCH_HIT, DP_SRCH_MISS,
    DP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    logic [2:0] cmd;
    logic       full;
    logic       cnt_zero;
    logic       pos_valid;
    logic       nl_zero;
    logic       nl_gt_len;
    logic       gap_at_cursor;
    logic       srch_end;
    logic       srch_hit;
    logic       srch_last;
    logic       out_free;
  } dp_sts_t;

endpackage

### rtl/gbts_ctrl.sv
module gbts_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  gbts_pkg::dp_sts_t sts,
  output gbts_pkg::dp_op_t  op
);
  import gbts_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    op = DP_NONE;
    in_stall = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          op = DP_LOAD;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        op = DP_APPLY;
        state_next = S_DONE;
        case (sts.cmd)
          CMD_INSERT: begin
            if (!sts.full) begin
              op = DP_NONE;
              state_next = S_MOVE;
            end
          end
          CMD_DELETE: begin
            if (!sts.cnt_zero) begin
              op = DP_NONE;
              state_next = S_MOVE;
            end
          end
          CMD_READ: begin
            if (sts.pos_valid) begin
              op = DP_READ_ISSUE;
              state_next = S_READ_WAIT;
            end
          end
          CMD_SEARCH: begin
            if (!sts.nl_zero && !sts.nl_gt_len) begin
              op = DP_SRCH_INIT;
              state_next = S_SRCH_RD;
            end
          end
          default: begin
            op = DP_APPLY;
          end
        endcase
      end
      S_MOVE: begin
        if (sts.gap_at_cursor) begin
          op = DP_APPLY;
          state_next = S_DONE;
        end else begin
          op = DP_MOVE_RD;
          state_next = S_MOVE_WR;
        end
      end
      S_MOVE_WR: begin
        op = DP_MOVE_WR;
        state_next = S_MOVE;
      end
      S_READ_WAIT: begin
        op = DP_READ_DONE;
        state_next = S_DONE;
      end
      S_SRCH_RD: begin
        if (sts.srch_end) begin
          op = DP_SRCH_MISS;
          state_next = S_DONE;
        end else begin
          op = DP_SRCH_RD;
          state_next = S_SRCH_CMP;
        end
      end
      S_SRCH_CMP: begin
        if (sts.srch_hit && sts.srch_last) begin
          op = DP_SRCH_HIT;
          state_next = S_DONE;
        end else if (sts.srch_hit) begin
          op = DP_SRCH_NEXTJ;
          state_next = S_SRCH_RD;
        end else begin
          op = DP_SRCH_NEXTI;
          state_next = S_SRCH_RD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          op = DP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/gbts_dp.sv
module gbts_dp #(
  parameter int CAPACITY = 4096,
  parameter int NEEDLE_MAX = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  gbts_pkg::dp_op_t  op,
  output gbts_pkg::dp_sts_t sts,
  input  logic [2:0]        cmd,
  input  logic [12:0]       position,
  input  logic [7:0]        data_byte,
  input  logic [12:0]       count,
  input  logic              needle_start,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [7:0]        byte_out,
  output logic [12:0]       position_out,
  output logic [12:0]       text_length,
  output logic              modified
);
  import gbts_pkg::*;

  localparam int PW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int NLW = $clog2(NEEDLE_MAX + 1);
  localparam int NAW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
  localparam int XW = (PW > 13) ? PW : 13;
  localparam int CW = ((PW > NLW) ? PW : NLW) + 1;
  localparam logic [PW-1:0] CAP_P = PW'(CAPACITY);
  localparam logic [NLW-1:0] NMAX_N = NLW'(NEEDLE_MAX);

  logic [7:0] text_mem [CAPACITY];
  logic [7:0] needle_mem [NEEDLE_MAX];
  logic [7:0] text_rdata, needle_rdata;

  logic [PW-1:0] gap_first, gap_after, cursor;
  logic dirty;
  logic [NLW-1:0] nlen;

  logic [2:0] req_cmd;
  logic [XW-1:0] req_pos, req_cnt;
  logic [7:0] req_byte;
  logic req_start;

  logic [1:0] res_status;
  logic [7:0] res_byte;
  logic res_found;
  logic [PW-1:0] res_match;
  logic [PW-1:0] si;
  logic [NLW-1:0] sj;

  logic [PW-1:0] len, gap_span, room, cnt_clip, goto_tgt, pos_p, srch_lpos;
  logic [AW-1:0] read_phys, srch_phys, t_raddr, t_waddr;
  logic [7:0] t_wdata;
  logic t_we, move_left, full;
  logic [NLW-1:0] nl_eff;

  always_comb begin
    gap_span = gap_after - gap_first;
    len = CAP_P - gap_span;
    full = (gap_span == '0);
    room = len - cursor;
    cnt_clip = (req_cnt > XW'(room)) ? room : PW'(req_cnt);
    goto_tgt = (req_pos > XW'(len)) ? len : PW'(req_pos);
    pos_p = PW'(req_pos);
    read_phys = AW'((pos_p < gap_first) ? pos_p : pos_p + gap_span);
    srch_lpos = si + PW'(sj);
    srch_phys = AW'((srch_lpos < gap_first) ? srch_lpos : srch_lpos + gap_span);
    nl_eff = req_start ? '0 : nlen;
    move_left = (cursor < gap_first);

    sts.cmd = req_cmd;
    sts.full = full;
    sts.cnt_zero = (req_cnt == '0);
    sts.pos_valid = (req_pos < XW'(len));
    sts.nl_zero = (nlen == '0);
    sts.nl_gt_len = (CW'(nlen) > CW'(len));
    sts.gap_at_cursor = (gap_first == cursor);
    sts.srch_end = ((CW'(si) + CW'(nlen)) > CW'(len));
    sts.srch_hit = (text_rdata == needle_rdata);
    sts.srch_last = (sj == nlen - NLW'(1));
    sts.out_free = !out_valid || !out_stall;

    case (op)
      DP_MOVE_RD:    t_raddr = move_left ? AW'(gap_first - PW'(1)) : AW'(gap_after);
      DP_READ_ISSUE: t_raddr = read_phys;
      default:       t_raddr = srch_phys;
    endcase

    t_we = 1'b0;
    t_waddr = AW'(gap_first);
    t_wdata = req_byte;
    if (op == DP_MOVE_WR) begin
      t_we = 1'b1;
      t_waddr = move_left ? AW'(gap_after - PW'(1)) : AW'(gap_first);
      t_wdata = text_rdata;
    end else if (op == DP_APPLY && req_cmd == CMD_INSERT && !full) begin
      t_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (t_we) begin
      text_mem[t_waddr] <= t_wdata;
    end
    text_rdata <= text_mem[t_raddr];
  end

  always_ff @(posedge clk) begin
    if (op == DP_APPLY && req_cmd == CMD_NEEDLE && nl_eff < NMAX_N) begin
      needle_mem[NAW'(nl_eff)] <= req_byte;
    end
    needle_rdata <= needle_mem[NAW'(sj)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_first <= '0;
      gap_after <= CAP_P;
      cursor <= '0;
      dirty <= 1'b0;
      nlen <= '0;
      out_valid <= 1'b0;
    end else begin
      if (op == DP_PUBLISH) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (op)
        DP_LOAD: begin
          req_cmd <= cmd;
          req_pos <= XW'(position);
          req_byte <= data_byte;
          req_cnt <= XW'(count);
          req_start <= needle_start;
          res_status <= ST_OK;
          res_byte <= '0;
          res_found <= 1'b0;
        end
        DP_MOVE_WR: begin
          if (move_left) begin
            gap_first <= gap_first - PW'(1);
            gap_after <= gap_after - PW'(1);
          end else begin
            gap_first <= gap_first + PW'(1);
            gap_after <= gap_after + PW'(1);
          end
        end
        DP_APPLY: begin
          case (req_cmd)
            CMD_GOTO: cursor <= goto_tgt;
            CMD_INSERT: begin
              if (full) begin
                res_status <= ST_NO_SPACE;
              end else begin
                gap_first <= gap_first + PW'(1);
                cursor <= cursor + PW'(1);
                dirty <= 1'b1;
              end
            end
            CMD_DELETE: begin
              if (req_cnt != '0) begin
                gap_after <= gap_after + cnt_clip;
                dirty <= 1'b1;
              end
            end
            CMD_READ: res_status <= ST_INVALID;
            CMD_NEEDLE: begin
              if (nl_eff < NMAX_N) begin
                nlen <= nl_eff + NLW'(1);
              end else begin
                nlen <= nl_eff;
                res_status <= ST_NO_SPACE;
              end
            end
            CMD_SEARCH: res_status <= (nlen == '0) ? ST_INVALID : ST_NOT_FOUND;
            default: res_status <= ST_INVALID;
          endcase
        end
        DP_READ_DONE: res_byte <= text_rdata;
        DP_SRCH_INIT: begin
          si <= '0;
          sj <= '0;
        end
        DP_SRCH_NEXTJ: sj <= sj + NLW'(1);
        DP_SRCH_NEXTI: begin
          si <= si + PW'(1);
          sj <= '0;
        end
        DP_SRCH_HIT: begin
          res_found <= 1'b1;
          res_match <= si;
        end
        DP_SRCH_MISS: res_status <= ST_NOT_FOUND;
        DP_PUBLISH: begin
          status <= res_status;
          byte_out <= res_byte;
          position_out <= 13'(res_found ? res_match : cursor);
          text_length <= 13'(len);
          modified <= dirty;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### rtl/gap_buffer_text_store.sv
// Text store kept as a gap buffer in one single-port-write memory of CAPACITY bytes.
// One request is handled at a time and gives one result; a new request is taken
// while the previous result still waits in the output register. Goto, needle and
// rejected requests are decoded and applied before the result is published; a read
// instead issues a text memory read and waits for its data. Insert and delete first
// move the gap to the cursor one byte at a time, since every moved byte needs a read
// and a write of the text memory. A search reads the text and needle memories once
// for each byte compared. Editing near the previous edit point therefore stays cheap.
module gap_buffer_text_store #(
  parameter int CAPACITY = 4096,
  parameter int NEEDLE_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  cmd,
  input  logic [12:0] position,
  input  logic [7:0]  data_byte,
  input  logic [12:0] count,
  input  logic        needle_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  byte_out,
  output logic [12:0] position_out,
  output logic [12:0] text_length,
  output logic        modified
);
  import gbts_pkg::*;
  `include "gap_buffer_text_store_defines.svh"

  dp_op_t op;
  dp_sts_t sts;

  gbts_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts(sts),
    .op(op)
  );

  gbts_dp #(
    .CAPACITY(CAPACITY),
    .NEEDLE_MAX(NEEDLE_MAX)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .op(op),
    .sts(sts),
    .cmd(cmd),
    .position(position),
    .data_byte(data_byte),
    .count(count),
    .needle_start(needle_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .byte_out(byte_out),
    .position_out(position_out),
    .text_length(text_length),
    .modified(modified)
  );

  `GBTS_ASSERT_NOW(a_pos_in_text, out_valid, position_out <= text_length)
  `GBTS_ASSERT_NOW(a_byte_only_ok, out_valid && status != ST_OK, byte_out == 8'd0)
  `GBTS_ASSERT_NEXT(a_dirty_sticks, out_valid && modified, modified)
  `GBTS_ASSERT_NOW(a_publish_free, op == DP_PUBLISH, !out_valid || !out_stall)

endmodule
